[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property that also holds while reset is held
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/u2a_pkg.sv]
package u2a_pkg;

    localparam int VAL_W        = 64;
    localparam int ADDR_BITS    = 64;
    localparam int NUM_BITS     = 32;

    // floor(NUM_BITS * log10(2)) + 1 decimal digits cover the widest number
    localparam int DEC_DIGITS   = ((NUM_BITS * 1233) >> 12) + 1;
    localparam int BCD_W        = 4 * DEC_DIGITS;
    localparam int HEX_NIBBLES  = (NUM_BITS + 3) / 4;
    localparam int ADDR_NIBBLES = (ADDR_BITS + 3) / 4;
    localparam int WORK_W       = (BCD_W > VAL_W) ? BCD_W : VAL_W;
    localparam int MAX_DIGITS   = (DEC_DIGITS > ADDR_NIBBLES) ? DEC_DIGITS : ADDR_NIBBLES;
    localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W    = $clog2(NUM_BITS);

    localparam logic [VAL_W-1:0] ADDR_MASK = {VAL_W{1'b1}} >> (VAL_W - ADDR_BITS);
    localparam logic [VAL_W-1:0] NUM_MASK  = {VAL_W{1'b1}} >> (VAL_W - NUM_BITS);

    localparam logic [1:0] CMD_DEC    = 2'd0;
    localparam logic [1:0] CMD_HEX_LO = 2'd1;
    localparam logic [1:0] CMD_HEX_UP = 2'd2;
    localparam logic [1:0] CMD_ADDR   = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_UP_A  = 7'h41;
    localparam logic [6:0] CH_X     = 7'h78;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_char;

    function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [6:0] base;
        if (nib < 4'd10) begin
            return CH_ZERO + 7'(nib);
        end
        base = upper ? CH_UP_A : CH_LOW_A;
        return base + 7'(nib) - 7'd10;
    endfunction

endpackage

[rtl/u2a_front.sv]
`include "assert_macros.svh"

module u2a_front
    import u2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_command,
    input  logic [63:0] i_value,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_take
);

    t_item       r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_count;
    logic        n_wr;
    logic        n_rd;
    logic [1:0]  n_count;
    logic        w_in;
    logic        w_out;
    t_item       w_item;

    assign full         = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd];
    assign w_in         = push && !full;
    assign w_out        = i_take && o_item_valid;

    // mask to the width that the mode prints
    always_comb begin
        w_item.cmd   = i_command;
        w_item.value = (i_command == CMD_ADDR) ? (i_value & ADDR_MASK) : (i_value & NUM_MASK);
    end

    always_comb begin
        n_wr    = w_in ? ~r_wr : r_wr;
        n_rd    = w_out ? ~r_rd : r_rd;
        n_count = r_count + 2'(w_in) - 2'(w_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr] <= w_item;
        end
    end

    `ASSERT_ALWAYS(ast_front_count, !i_rst_n || r_count != 2'd3, "front queue count out of range")
    `ASSERT_CLK(ast_front_take, i_take |-> o_item_valid, "item taken from empty front queue")

endmodule

[rtl/u2a_back.sv]
`include "assert_macros.svh"

module u2a_back
    import u2a_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_take,
    input  logic  i_oq_full,
    output logic  o_push,
    output t_char o_char
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DABBLE = 3'd1;
    localparam logic [2:0] ST_PRE0   = 3'd2;
    localparam logic [2:0] ST_PRE1   = 3'd3;
    localparam logic [2:0] ST_SKIP   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [1:0]           r_mode;
    logic [1:0]           n_mode;
    logic [WORK_W-1:0]    r_work;
    logic [WORK_W-1:0]    n_work;
    logic [NUM_BITS-1:0]  r_bin;
    logic [NUM_BITS-1:0]  n_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     n_bcd;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [BIT_CNT_W-1:0] n_bit_cnt;
    logic [BCD_W-1:0]     w_adj;
    logic [3:0]           w_top;

    assign w_top = r_work[WORK_W-1 -: 4];

    // add-3 correction of every bcd digit before the shift
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            d = r_bcd[4*k +: 4];
            w_adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_work    = r_work;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_bit_cnt = r_bit_cnt;
        o_take    = 1'b0;
        o_push    = 1'b0;
        o_char.character = hex_char(w_top, r_mode == CMD_HEX_UP);
        o_char.last      = (r_cnt == CNT_W'(1));
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_take = 1'b1;
                    n_mode = i_item.cmd;
                    case (i_item.cmd)
                        CMD_DEC: begin
                            n_bin     = i_item.value[NUM_BITS-1:0];
                            n_bcd     = '0;
                            n_bit_cnt = BIT_CNT_W'(NUM_BITS - 1);
                            n_state   = ST_DABBLE;
                        end
                        CMD_ADDR: begin
                            n_work  = WORK_W'(i_item.value[ADDR_BITS-1:0])
                                      << (WORK_W - 4 * ADDR_NIBBLES);
                            n_cnt   = CNT_W'(ADDR_NIBBLES);
                            n_state = ST_PRE0;
                        end
                        default: begin
                            n_work  = WORK_W'(i_item.value[NUM_BITS-1:0])
                                      << (WORK_W - 4 * HEX_NIBBLES);
                            n_cnt   = CNT_W'(HEX_NIBBLES);
                            n_state = ST_SKIP;
                        end
                    endcase
                end
            end
            ST_DABBLE: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[NUM_BITS-1]};
                n_bin = {r_bin[NUM_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
                if (r_bit_cnt == '0) begin
                    n_work  = WORK_W'(n_bcd) << (WORK_W - BCD_W);
                    n_cnt   = CNT_W'(DEC_DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_PRE0: begin
                o_char.character = CH_ZERO;
                o_char.last      = 1'b0;
                if (!i_oq_full) begin
                    o_push  = 1'b1;
                    n_state = ST_PRE1;
                end
            end
            ST_PRE1: begin
                o_char.character = CH_X;
                o_char.last      = 1'b0;
                if (!i_oq_full) begin
                    o_push  = 1'b1;
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (r_cnt > CNT_W'(1) && w_top == 4'd0) begin
                    n_work = r_work << 4;
                    n_cnt  = r_cnt - CNT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_oq_full) begin
                    o_push = 1'b1;
                    n_work = r_work << 4;
                    n_cnt  = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_work    <= n_work;
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
    end

    `ASSERT_CLK(ast_emit_cnt, (r_state == ST_EMIT || r_state == ST_SKIP) |-> (r_cnt != '0),
        "digit count ran out while emitting")
    `ASSERT_CLK(ast_last_idle, (o_push && o_char.last) |=> (r_state == ST_IDLE),
        "last beat did not end the item")

endmodule

[rtl/u2a_outq.sv]
`include "assert_macros.svh"

module u2a_outq
    import u2a_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_char i_char,
    output logic  o_full,
    output logic  empty,
    input  logic  pop,
    output t_char o_char
);

    t_char      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_in;
    logic       w_out;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_char = r_q[r_rd];
    assign w_in   = i_push && !o_full;
    assign w_out  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= w_in ? ~r_wr : r_wr;
            r_rd    <= w_out ? ~r_rd : r_rd;
            r_count <= r_count + 2'(w_in) - 2'(w_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr] <= i_char;
        end
    end

    `ASSERT_CLK(ast_outq_overflow, i_push |-> !o_full, "beat pushed into full result queue")

endmodule

[rtl/unsigned_to_ascii_radix_unit.sv]
// Converts one number per item to ASCII text, most significant digit first, without
// leading zeros, one character per result beat, with o_last on the final one. Commands:
// unsigned decimal, lowercase hex, uppercase hex (low 32 bits each) and address ("0x" then
// lowercase hex of all 64 bits). Items are worked one at a time by a conversion sequencer
// behind a two-entry input queue, and results leave through a two-entry result queue.
// With z skipped leading zero digits and d printed digits, a decimal item is taken, then
// converted by a double-dabble pass of one bit per cycle, then goes through the skip step
// and the emit step; a hex item goes from being taken straight to the skip step, and an
// address item first emits "0x". z + d is 10, 8 and 16 in decimal, hex and address mode,
// the skip and the emit steps running one digit per cycle when the result side does not stall.
module unsigned_to_ascii_radix_unit
    import u2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_character,
    output logic        o_last
);

    logic  w_item_valid;
    t_item w_item;
    logic  w_take;
    logic  w_oq_full;
    logic  w_push;
    t_char w_char;
    t_char w_out_char;

    u2a_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_value      (i_value),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    u2a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .i_oq_full    (w_oq_full),
        .o_push       (w_push),
        .o_char       (w_char)
    );

    u2a_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_char  (w_char),
        .o_full  (w_oq_full),
        .empty   (empty),
        .pop     (pop),
        .o_char  (w_out_char)
    );

    assign o_character = w_out_char.character;
    assign o_last      = w_out_char.last;

endmodule
